/* src/salted_arx_hash_256_core_defines.svh */
// Assertion macros for the port-level checker of the hash core.
// Depends on nothing; the using scope must provide clk and rst.
`ifndef SALTED_ARX_HASH_256_CORE_DEFINES_SVH
`define SALTED_ARX_HASH_256_CORE_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define SAH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define SAH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sah_pkg.sv */
// Shared types and constants of the salted ARX hash core.
// Depends on nothing; every RTL file of the core imports it.
package sah_pkg;

  // Default for the minimum padded message length in bytes.
  localparam int unsigned MIN_PADDED_BYTES_DEF = 256;

  // Number of ARX rounds run after each 32-byte block.
  localparam int unsigned ROUNDS = 4;

  // Saturation value of the byte counter.
  localparam logic [8:0] BYTE_CAP = 9'd256;

  // Depth of the command queue between front and back.
  localparam int unsigned CMD_DEPTH = 4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SALT_WORDS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SALT_PAIR_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SALT_PAIR_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SALT_PAIR_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SALT_PAIR_D = 3'd4;

  // Unsalted starting values of the mix set, entry 0 in the low word.
  localparam logic [7:0][31:0] MIX_INIT = {
    32'h8a348b7d, 32'hb5f3810a, 32'h45000057, 32'h31ba94b9,
    32'hb8a79b02, 32'h0059c491, 32'hacdef012, 32'h72000000
  };

  // Salt configuration as held by the register file.
  typedef struct packed {
    logic [3:0]       count;
    logic [3:0][63:0] pair;
  } salt_cfg_t;

  // One classified work command from the front to the back.
  typedef struct packed {
    logic [31:0] word;    // data word with invalid bytes cleared
    logic        absorb;  // word carries at least one byte
    logic        last;    // final word of the message
    logic        start;   // first word of a message: load the mix set
    logic [3:0]  pad;     // zero blocks to add after the last block
  } cmd_t;

endpackage

/* src/sah_front.sv */
// Front end: accepts message words, masks and classifies them into commands.
// Depends on sah_pkg; feeds sah_cmd_fifo.
module sah_front #(
  parameter int unsigned MIN_PADDED_BYTES = sah_pkg::MIN_PADDED_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   msg_word,
  input  logic [2:0]    valid_bytes,
  input  logic          is_last,
  input  logic          push,
  input  logic          q_full,
  output logic          q_push,
  output sah_pkg::cmd_t q_data
);
  import sah_pkg::*;

  // Whole 32-byte blocks that a message must reach before the digest.
  localparam logic [3:0] PAD_TARGET = 4'((MIN_PADDED_BYTES + 31) / 32);

  typedef enum logic {
    PH_AWAIT,
    PH_ABSORB
  } phase_t;

  phase_t      phase;
  logic [8:0]  bytes_seen;
  logic        accept;
  logic [2:0]  vb;
  logic [31:0] masked;
  logic [2:0]  add;
  logic [9:0]  sum;
  logic [8:0]  bytes_next;
  logic [9:0]  round_up;
  logic [3:0]  done_blocks;

  // Clamp the byte count, clear invalid bytes and update the byte count.
  always_comb begin
    accept = push && !q_full;
    vb = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
    unique case (vb)
      3'd1:    masked = {msg_word[31:24], 24'd0};
      3'd2:    masked = {msg_word[31:16], 16'd0};
      3'd3:    masked = {msg_word[31:8], 8'd0};
      default: masked = msg_word;
    endcase
    add = is_last ? vb : 3'd4;
    sum = {1'b0, bytes_seen} + {7'd0, add};
    bytes_next = bytes_seen;
    if (vb != 3'd0) begin
      bytes_next = (sum > {1'b0, BYTE_CAP}) ? BYTE_CAP : sum[8:0];
    end
    round_up = {1'b0, bytes_next} + 10'd31;
    done_blocks = round_up[8:5];
  end

  // Build the command; the padding count only matters on the last word.
  always_comb begin
    q_push = accept;
    q_data.word = masked;
    q_data.absorb = (vb != 3'd0);
    q_data.last = is_last;
    q_data.start = (phase == PH_AWAIT);
    q_data.pad = (done_blocks < PAD_TARGET) ? (PAD_TARGET - done_blocks) : 4'd0;
  end

  // Message phase and byte count.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_AWAIT;
      bytes_seen <= '0;
    end else if (accept) begin
      if (is_last) begin
        phase <= PH_AWAIT;
        bytes_seen <= '0;
      end else begin
        phase <= PH_ABSORB;
        bytes_seen <= bytes_next;
      end
    end
  end

endmodule

/* src/sah_cmd_fifo.sv */
// Short command queue between the front end and the back end.
// Depends on sah_pkg for the command type and depth.
module sah_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  sah_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output sah_pkg::cmd_t rd_data,
  output logic          empty
);
  import sah_pkg::*;

  localparam int unsigned AW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_PTR = AW'(CMD_DEPTH - 1);
  localparam logic [AW:0] DEPTH_CNT = (AW + 1)'(CMD_DEPTH);

  cmd_t          mem [CMD_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_wr;
  logic          do_rd;

  // Status and show-ahead read of the oldest entry.
  always_comb begin
    full = (count == DEPTH_CNT);
    empty = (count == '0);
    do_wr = wr_en && !full;
    do_rd = rd_en && !empty;
    rd_data = mem[rd_ptr];
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/sah_back.sv */
// Back end: absorbs words into the chain, runs ARX rounds, pads and emits the digest.
// Depends on sah_pkg; reads commands from sah_cmd_fifo.
module sah_back (
  input  logic              clk,
  input  logic              rst,
  input  sah_pkg::salt_cfg_t salt,
  input  sah_pkg::cmd_t     head,
  input  logic              head_valid,
  output logic              head_pop,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_index,
  output logic              is_final,
  output logic              empty,
  input  logic              pop
);
  import sah_pkg::*;

  localparam int unsigned RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [RW-1:0] LAST_ROUND = RW'(ROUNDS - 1);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_ROUNDS,
    ST_FINISH,
    ST_EMIT
  } state_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned c);
    return (v << c) | (v >> (32 - c));
  endfunction

  // One ARX round followed by the swap of chain words 0 and 1.
  function automatic logic [7:0][31:0] arx_round(input logic [7:0][31:0] h);
    logic [7:0][31:0] n;
    n[0] = h[0] + h[1];
    n[1] = rotl(h[1] ^ h[2], 2);
    n[2] = h[2] + h[3];
    n[3] = rotl(h[3] ^ h[4], 5);
    n[4] = h[4] + h[5];
    n[5] = rotl(h[5] ^ h[6], 7);
    n[6] = h[6] + h[7];
    n[7] = rotl(h[7] ^ n[0], 12);
    return {n[7], n[6], n[5], n[4], n[3], n[2], n[0], n[1]};
  endfunction

  // Mix set at message start: the leading entries are salted and incremented.
  function automatic logic [7:0][31:0] salted_mix(input salt_cfg_t s);
    logic [7:0][31:0] m;
    logic [3:0]       n;
    logic [31:0]      sw;
    n = (s.count > 4'd8) ? 4'd8 : s.count;
    for (int i = 0; i < 8; i++) begin
      sw = i[0] ? s.pair[i >> 1][31:0] : s.pair[i >> 1][63:32];
      m[i] = (4'(i) < n) ? ((MIX_INIT[i] ^ sw) + 32'd1) : MIX_INIT[i];
    end
    return m;
  endfunction

  state_t           state;
  logic [7:0][31:0] chain;
  logic [7:0][31:0] mix;
  logic [2:0]       slot;
  logic [RW-1:0]    rnd;
  logic [2:0]       k;
  logic             start_done;
  logic             pending_fin;
  logic [3:0]       pad_left;
  logic             out_valid;

  logic             do_start;
  logic             run_take;
  logic             fin_absorb;
  logic             do_absorb;
  logic             do_round;
  logic             wrap;
  logic             emit_load;
  logic [31:0]      absorb_word;

  // Step decode for the current cycle.
  always_comb begin
    do_start = (state == ST_RUN) && head_valid && head.start && !start_done;
    run_take = (state == ST_RUN) && head_valid && !(head.start && !start_done);
    fin_absorb = (state == ST_FINISH) && ((slot != 3'd0) || (pad_left != 4'd0));
    do_absorb = (run_take && head.absorb) || fin_absorb;
    absorb_word = (state == ST_FINISH) ? 32'd0 : head.word;
    do_round = (state == ST_ROUNDS);
    wrap = do_absorb && (slot == 3'd7);
    emit_load = (state == ST_EMIT) && (!out_valid || pop);
    head_pop = run_take;
    empty = !out_valid;
  end

  // Chain and mix datapath; the chain shifts down while the digest goes out.
  always_ff @(posedge clk) begin
    if (do_start) begin
      chain <= '0;
      mix <= salted_mix(salt);
    end else if (do_absorb) begin
      chain[slot] <= chain[slot] ^ absorb_word ^ mix[slot];
      mix[slot] <= chain[slot] ^ absorb_word;
    end else if (do_round) begin
      chain <= arx_round(chain);
    end else if (emit_load) begin
      chain <= {32'd0, chain[7:1]};
    end
  end

  // Sequencer state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      slot <= '0;
      rnd <= '0;
      k <= '0;
      start_done <= 1'b0;
      pending_fin <= 1'b0;
      pad_left <= '0;
      out_valid <= 1'b0;
    end else begin
      if (do_start) begin
        slot <= '0;
      end else if (do_absorb) begin
        slot <= slot + 3'd1;
      end

      if (emit_load) begin
        out_valid <= 1'b1;
        digest_word <= chain[0];
        word_index <= k;
        is_final <= (k == 3'd7);
      end else if (pop) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_RUN: begin
          if (do_start) begin
            start_done <= 1'b1;
          end
          if (run_take) begin
            start_done <= 1'b0;
            pending_fin <= head.last;
            pad_left <= head.pad;
            if (wrap) begin
              state <= ST_ROUNDS;
              rnd <= '0;
            end else if (head.last) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_ROUNDS: begin
          rnd <= rnd + 1'b1;
          if (rnd == LAST_ROUND) begin
            state <= pending_fin ? ST_FINISH : ST_RUN;
          end
        end
        ST_FINISH: begin
          if (fin_absorb) begin
            // A padding block is charged when its first word goes in.
            if (slot == 3'd0) begin
              pad_left <= pad_left - 4'd1;
            end
            if (wrap) begin
              state <= ST_ROUNDS;
              rnd <= '0;
            end
          end else begin
            state <= ST_EMIT;
            k <= '0;
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            k <= k + 3'd1;
            if (k == 3'd7) begin
              state <= ST_RUN;
              pending_fin <= 1'b0;
            end
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

endmodule

/* src/salted_arx_hash_256_core.sv */
// Salted ARX hash core: the back end absorbs message words into the chain, and every
// 32-byte block adds four ARX rounds, run one per cycle while new words wait.
// A message start loads the mix set first; padding words go in as zero words and add
// rounds as message blocks do. Digest words leave at one per cycle while pop is high.
// Synchronous reset clears control and the configuration registers; no clearing pass.
module salted_arx_hash_256_core #(
  parameter int unsigned MIN_PADDED_BYTES = sah_pkg::MIN_PADDED_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [31:0]                     msg_word,
  input  logic [2:0]                      valid_bytes,
  input  logic                            is_last,
  input  logic                            push,
  output logic                            full,
  output logic [31:0]                     digest_word,
  output logic [2:0]                      word_index,
  output logic                            is_final,
  output logic                            empty,
  input  logic                            pop,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sah_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                     cfg_data
);
  import sah_pkg::*;

  salt_cfg_t salt;
  cmd_t      q_wr_data;
  cmd_t      q_rd_data;
  logic      q_push;
  logic      q_pop;
  logic      q_empty;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      salt <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SALT_WORDS:  salt.count <= cfg_data[3:0];
        REG_SALT_PAIR_A: salt.pair[0] <= cfg_data;
        REG_SALT_PAIR_B: salt.pair[1] <= cfg_data;
        REG_SALT_PAIR_C: salt.pair[2] <= cfg_data;
        REG_SALT_PAIR_D: salt.pair[3] <= cfg_data;
        default:         salt <= salt;
      endcase
    end
  end

  sah_front #(
    .MIN_PADDED_BYTES(MIN_PADDED_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .msg_word   (msg_word),
    .valid_bytes(valid_bytes),
    .is_last    (is_last),
    .push       (push),
    .q_full     (full),
    .q_push     (q_push),
    .q_data     (q_wr_data)
  );

  sah_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_push),
    .wr_data(q_wr_data),
    .full   (full),
    .rd_en  (q_pop),
    .rd_data(q_rd_data),
    .empty  (q_empty)
  );

  sah_back u_back (
    .clk        (clk),
    .rst        (rst),
    .salt       (salt),
    .head       (q_rd_data),
    .head_valid (!q_empty),
    .head_pop   (q_pop),
    .digest_word(digest_word),
    .word_index (word_index),
    .is_final   (is_final),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

/* src/sah_checker.sv */
// Port-level checks of the hash core's result stream, bound to the top level.
// Depends on salted_arx_hash_256_core_defines.svh for the assertion macros.
`include "salted_arx_hash_256_core_defines.svh"

module sah_checker (
  input logic        clk,
  input logic        rst,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        is_final,
  input logic        empty,
  input logic        pop
);

  // A waiting result stays put until its transfer.
  `SAH_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(digest_word) && $stable(word_index) && $stable(is_final), "result changed while waiting")

  // The final flag marks exactly the eighth digest word.
  `SAH_ASSERT_NOW(a_final_on_last, !empty, is_final == (word_index == 3'd7), "final flag mismatch")

  // Digest words follow each other without a gap and in order.
  `SAH_ASSERT_NEXT(a_index_steps, !empty && pop && !is_final, !empty && (word_index == $past(word_index) + 3'd1), "digest word order broken")

  // Nothing follows the final word until the next message is hashed.
  `SAH_ASSERT_NEXT(a_idle_after_final, !empty && pop && is_final, empty, "result after final word")

endmodule

bind salted_arx_hash_256_core sah_checker u_sah_checker (
  .clk        (clk),
  .rst        (rst),
  .digest_word(digest_word),
  .word_index (word_index),
  .is_final   (is_final),
  .empty      (empty),
  .pop        (pop)
);

/* sim/tb_salted_arx_hash_256_core.sv */
// Self-checking testbench for the salted ARX hash core: random and directed messages
// are hashed by a local model and every digest word is compared in order.
// Depends on sah_pkg and the salted_arx_hash_256_core RTL only.
module tb_salted_arx_hash_256_core;
  import sah_pkg::*;

  localparam int unsigned MIN_PAD = MIN_PADDED_BYTES_DEF;
  localparam int unsigned ITEM_TARGET = 420;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned IDLE_PERCENT = 12;
  // Index past the last register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // One expected digest word.
  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        fin;
  } digest_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [31:0] msg_word = '0;
  logic [2:0]  valid_bytes = '0;
  logic        is_last = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        is_final;
  logic        empty;
  logic        pop = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // Model state and its copy of the configuration.
  logic [31:0] chain_q [8];
  logic [31:0] mix_q [8];
  int          slot_q;
  int          bytes_q;
  bit          msg_open;
  logic [3:0]  salt_count;
  logic [63:0] salt_pair [4];

  digest_t     digest_q [$];
  int          error_count;
  int          messages_sent;
  int          words_sent;
  int          random_items;
  int          digests_checked;
  int          salt_settings;
  bit          no_idle;

  salted_arx_hash_256_core i_dut (
    .clk(clk), .rst(rst),
    .msg_word(msg_word), .valid_bytes(valid_bytes), .is_last(is_last),
    .push(push), .full(full),
    .digest_word(digest_word), .word_index(word_index), .is_final(is_final),
    .empty(empty), .pop(pop),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [31:0] rotl32(logic [31:0] v, int c);
    return (v << c) | (v >> (32 - c));
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Folds one word into the chain; a full block triggers the ARX rounds.
  function automatic void absorb_word(logic [31:0] w);
    logic [31:0] t;
    int s;
    s = slot_q;
    chain_q[s] = chain_q[s] ^ w ^ mix_q[s];
    mix_q[s] = mix_q[s] ^ chain_q[s];
    slot_q = (s + 1) % 8;
    if (slot_q == 0) begin
      for (int r = 0; r < ROUNDS; r++) begin
        chain_q[0] = chain_q[0] + chain_q[1];
        chain_q[1] = rotl32(chain_q[1] ^ chain_q[2], 2);
        chain_q[2] = chain_q[2] + chain_q[3];
        chain_q[3] = rotl32(chain_q[3] ^ chain_q[4], 5);
        chain_q[4] = chain_q[4] + chain_q[5];
        chain_q[5] = rotl32(chain_q[5] ^ chain_q[6], 7);
        chain_q[6] = chain_q[6] + chain_q[7];
        chain_q[7] = rotl32(chain_q[7] ^ chain_q[0], 12);
        t = chain_q[0];
        chain_q[0] = chain_q[1];
        chain_q[1] = t;
      end
    end
  endfunction

  // Updates the model for one accepted word and queues the digest on the last one.
  function automatic void hash_accepted_word(logic [31:0] w, logic [2:0] vb, logic last);
    int v;
    int n;
    logic [31:0] sw;
    digest_t d;
    v = (vb > 3'd4) ? 4 : int'(vb);
    // The mix set is salted when the first word of a message arrives.
    if (!msg_open) begin
      n = (salt_count > 4'd8) ? 8 : int'(salt_count);
      for (int i = 0; i < 8; i++) begin
        chain_q[i] = '0;
        mix_q[i] = MIX_INIT[i];
      end
      for (int i = 0; i < n; i++) begin
        sw = i[0] ? salt_pair[i >> 1][31:0] : salt_pair[i >> 1][63:32];
        mix_q[i] = (mix_q[i] ^ sw) + 32'd1;
      end
      slot_q = 0;
      bytes_q = 0;
      msg_open = 1'b1;
    end
    if (v > 0) begin
      if (v < 4) w = w & (32'hffff_ffff << (32 - 8 * v));
      absorb_word(w);
      bytes_q += last ? v : 4;
      if (bytes_q > 256) bytes_q = 256;
    end
    if (!last) return;
    // Close the partial block, then pad short messages with whole zero blocks.
    while (slot_q != 0) absorb_word('0);
    if (bytes_q < MIN_PAD) begin
      for (int b = (bytes_q + 31) / 32; b < (MIN_PAD + 31) / 32; b++) begin
        for (int i = 0; i < 8; i++) absorb_word('0);
      end
    end
    for (int k = 0; k < 8; k++) begin
      d.word = chain_q[k];
      d.index = 3'(k);
      d.fin = (k == 7);
      digest_q.push_back(d);
    end
    for (int i = 0; i < 8; i++) chain_q[i] = '0;
    slot_q = 0;
    bytes_q = 0;
    msg_open = 1'b0;
    messages_sent++;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, exp_v, got_v);
    error_count++;
  endtask

  // Result side: checks each transfer against the oldest expected digest word.
  always @(posedge clk) begin
    digest_t d;
    if (!rst && pop && !empty) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest word", '0, digest_word);
      end else begin
        d = digest_q.pop_front();
        if (digest_word !== d.word) report_mismatch("digest_word", d.word, digest_word);
        if (word_index !== d.index) begin
          report_mismatch("word_index", 32'(d.index), 32'(word_index));
        end
        if (is_final !== d.fin) report_mismatch("is_final", 32'(d.fin), 32'(is_final));
        digests_checked++;
      end
    end
    pop <= rst ? 1'b0 : (no_idle || $urandom_range(99) >= IDLE_PERCENT);
  end

  // Sends one message word, idling at random first; leaves push high afterwards.
  task automatic send_word(logic [31:0] w, logic [2:0] vb, logic last);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    msg_word <= w;
    valid_bytes <= vb;
    is_last <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    hash_accepted_word(w, vb, last);
    words_sent++;
    if (vb != 3'd0 || last) random_items++;
  endtask

  // Stops sending, waits for every expected digest word, then lets the core settle.
  task automatic wait_drained();
    push <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SALT_WORDS:  salt_count = data[3:0];
      REG_SALT_PAIR_A: salt_pair[0] = data;
      REG_SALT_PAIR_B: salt_pair[1] = data;
      REG_SALT_PAIR_C: salt_pair[2] = data;
      REG_SALT_PAIR_D: salt_pair[3] = data;
      default: ;
    endcase
  endtask

  // Loads a complete salt setting while the core is idle.
  task automatic write_salt(logic [3:0] count, logic [63:0] a, logic [63:0] b,
                            logic [63:0] c, logic [63:0] d, bit poke_unused);
    wait_drained();
    write_reg(REG_SALT_WORDS, {60'($urandom), count});
    write_reg(REG_SALT_PAIR_A, a);
    write_reg(REG_SALT_PAIR_B, b);
    write_reg(REG_SALT_PAIR_C, c);
    write_reg(REG_SALT_PAIR_D, d);
    if (poke_unused) write_reg(REG_UNUSED, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    salt_settings++;
  endtask

  // One message of random content; noisy messages carry odd byte counts anywhere.
  task automatic send_message(int n_words, bit noisy);
    logic [2:0] vb;
    logic last;
    for (int i = 0; i < n_words; i++) begin
      last = (i == n_words - 1);
      vb = last ? 3'($urandom_range(4)) : 3'd4;
      if (noisy && $urandom_range(3) == 0) vb = 3'($urandom_range(7));
      send_word(rand_word(), vb, last);
    end
  endtask

  // Byte count extremes, empty words and messages, with the reset configuration.
  task automatic test_word_edge_cases();
    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'hffff_ffff, 3'd4, 1'b1);
    send_word(32'hffff_ffff, 3'd1, 1'b1);
    send_word(32'hffff_ffff, 3'd2, 1'b1);
    send_word(32'hffff_ffff, 3'd3, 1'b1);
    send_word(32'hffff_ffff, 3'd7, 1'b1);
    send_word(32'ha5a5_a5a5, 3'd5, 1'b0);
    send_word(32'h5a5a_5a5a, 3'd6, 1'b1);
    // A short word before the end still counts as four bytes.
    send_word(32'h1234_5678, 3'd2, 1'b0);
    send_word(32'h9abc_def0, 3'd4, 1'b1);
    // Empty words inside a message and at its start are skipped.
    send_word(32'h1111_1111, 3'd4, 1'b0);
    send_word(32'h2222_2222, 3'd0, 1'b0);
    send_word(32'h3333_3333, 3'd4, 1'b1);
    send_word(32'hdead_beef, 3'd0, 1'b0);
    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'h0000_0000, 3'd4, 1'b1);
  endtask

  // Salt counts at both ends, past the top, and in between.
  task automatic test_salt_settings();
    write_salt(4'd8, '1, '1, '1, '1, 1'b1);
    send_message($urandom_range(1, 12), 1'b0);
    send_message($urandom_range(1, 12), 1'b0);
    write_salt(4'd15, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    send_message($urandom_range(1, 12), 1'b0);
    send_message($urandom_range(1, 12), 1'b0);
    write_salt(4'd1, {$urandom, $urandom}, '0, '0, '1, 1'b0);
    send_message($urandom_range(1, 12), 1'b0);
    write_salt(4'd0, '1, '1, '1, '1, 1'b0);
    send_message($urandom_range(1, 12), 1'b0);
  endtask

  // Messages ending on, just past, and well past block and padding boundaries.
  task automatic test_block_boundaries();
    write_salt(4'($urandom_range(8)), {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    send_message(8, 1'b0);
    send_message(9, 1'b0);
    send_message(64, 1'b0);
    send_message(65, 1'b0);
    send_message(72, 1'b0);
  endtask

  // Mostly well-formed random messages, some noisy, with salt changes in between.
  task automatic test_random_traffic();
    int msg_num;
    int len;
    msg_num = 0;
    while (random_items < ITEM_TARGET || msg_num < 8) begin
      if (msg_num % 8 == 7) begin
        write_salt(4'($urandom_range(15)), {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      end
      // Besides the salt changes, the sender holds off once until every digest has come back.
      if (msg_num == 2) wait_drained();
      no_idle = (msg_num >= 3 && msg_num < 7);
      case ($urandom_range(19))
        0:       len = $urandom_range(60, 80);
        1, 2, 3: len = $urandom_range(21, 40);
        default: len = $urandom_range(1, 20);
      endcase
      send_message(len, $urandom_range(4) == 0);
      msg_num++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      chain_q[i] = '0;
      mix_q[i] = '0;
    end
    for (int i = 0; i < 4; i++) salt_pair[i] = '0;
    salt_count = '0;
    slot_q = 0;
    bytes_q = 0;
    msg_open = 1'b0;
    error_count = 0;
    messages_sent = 0;
    words_sent = 0;
    random_items = 0;
    digests_checked = 0;
    salt_settings = 0;
    no_idle = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_word_edge_cases();
    random_items = 0;
    test_salt_settings();
    test_block_boundaries();
    test_random_traffic();

    wait_drained();
    if (digest_q.size() != 0) begin
      report_mismatch("digest words never delivered", 32'(digest_q.size()), '0);
    end
    $display("Hashed %0d messages from %0d words under %0d salt settings;",
             messages_sent, words_sent, salt_settings);
    $display("%0d digest words checked, %0d mismatches.", digests_checked, error_count);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* salted_arx_hash_256_core.f */
+incdir+src
src/sah_pkg.sv
src/sah_front.sv
src/sah_cmd_fifo.sv
src/sah_back.sv
src/salted_arx_hash_256_core.sv
src/sah_checker.sv
sim/tb_salted_arx_hash_256_core.sv
